// ===== hdl/box_point_query_core_assert.svh =====
// Assertion macros for the box point query block.
// Used by the top level only; expects clk and rst in scope.
`ifndef BOX_POINT_QUERY_CORE_ASSERT_SVH
`define BOX_POINT_QUERY_CORE_ASSERT_SVH

// Implication checked at every edge outside reset.
`define BPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpq check failed");

// Plain invariant checked at every edge outside reset.
`define BPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bpq invariant failed");

`endif

// ===== hdl/bpq_pkg.sv =====
// Shared types and constants for the box point query block.
// No dependencies.
`default_nettype none
package bpq_pkg;
  localparam int COORD_W   = 32;
  localparam int MARGIN_W  = 31;
  localparam int IDX_W     = 3;
  localparam int ENC_W     = 8;
  localparam int DIST_W    = 63;
  localparam int SQ_W      = 64;
  localparam int NUM_W     = COORD_W + ENC_W;
  localparam int DIV_STEPS = ENC_W;
  // capture + prepare + one stage per quotient bit
  localparam int LANE_DEPTH = DIV_STEPS + 2;
  // lanes plus two merge stages
  localparam int STAGES = LANE_DEPTH + 2;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_MAX_X  = 3'd3,
    REG_MAX_Y  = 3'd4,
    REG_MAX_Z  = 3'd5,
    REG_MARGIN = 3'd6,
    REG_NONE   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic              in_box;
    logic              inside_m;
    logic [SQ_W-1:0]   sq;
    logic [ENC_W-1:0]  enc;
  } lane_res_t;
endpackage
`default_nettype wire

// ===== hdl/bpq_if.sv =====
// Channel interfaces: point input, result output, register writes.
// Depends on bpq_pkg.
`default_nettype none
interface bpq_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpq_pkg::COORD_W-1:0] point_x;
  logic signed [bpq_pkg::COORD_W-1:0] point_y;
  logic signed [bpq_pkg::COORD_W-1:0] point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface bpq_result_if;
  logic                          valid;
  logic                          ready;
  logic                          inside_res;
  logic                          inside_margin;
  logic [bpq_pkg::DIST_W-1:0]    dist_sq;
  logic [bpq_pkg::ENC_W-1:0]     enc_x;
  logic [bpq_pkg::ENC_W-1:0]     enc_y;
  logic [bpq_pkg::ENC_W-1:0]     enc_z;
  modport source(output valid, inside_res, inside_margin, dist_sq, enc_x, enc_y, enc_z,
                 input ready);
  modport sink(input valid, inside_res, inside_margin, dist_sq, enc_x, enc_y, enc_z,
               output ready);
endinterface

interface bpq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpq_pkg::IDX_W-1:0]     index;
  logic [bpq_pkg::COORD_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpq_lane.sv =====
// One axis lane: containment flags, squared distance, pipelined quantizer divide.
// Depends on bpq_pkg.
`default_nettype none
module bpq_lane (
  input  wire logic                                 clk,
  input  wire logic [bpq_pkg::LANE_DEPTH-1:0]       en,
  input  wire logic signed [bpq_pkg::COORD_W-1:0]   point,
  input  wire logic signed [bpq_pkg::COORD_W-1:0]   lo,
  input  wire logic signed [bpq_pkg::COORD_W-1:0]   hi,
  input  wire logic [bpq_pkg::MARGIN_W-1:0]         margin,
  output bpq_pkg::lane_res_t                        res
);
  import bpq_pkg::*;

  logic signed [COORD_W-1:0] p_a;

  // prepare stage
  logic signed [COORD_W:0]   p33, lo33, hi33, size33, rel33, dlo33, dhi33;
  logic signed [COORD_W+1:0] p34, lom34, him34;
  logic                      in_c, inm_c, zero_c, full_c;
  logic [COORD_W-1:0]        d_c;
  logic [NUM_W-1:0]          num_c;

  logic                      in_b, inm_b, zero_b, full_b;
  logic [COORD_W-1:0]        d_b, size_b;
  logic [NUM_W-1:0]          num_b;

  always_ff @(posedge clk) begin
    if (en[0]) p_a <= point;
  end

  always_comb begin
    p33    = {p_a[COORD_W-1], p_a};
    lo33   = {lo[COORD_W-1], lo};
    hi33   = {hi[COORD_W-1], hi};
    size33 = hi33 - lo33;
    rel33  = p33 - lo33;
    dlo33  = lo33 - p33;
    dhi33  = p33 - hi33;
    p34    = {{2{p_a[COORD_W-1]}}, p_a};
    lom34  = {{2{lo[COORD_W-1]}}, lo} - signed'({3'b000, margin});
    him34  = {{2{hi[COORD_W-1]}}, hi} + signed'({3'b000, margin});
    in_c   = (p33 >= lo33) && (p33 <= hi33);
    inm_c  = (p34 >= lom34) && (p34 <= him34);
    // lower side is checked first so an inverted box measures from min
    if (p33 < lo33)      d_c = dlo33[COORD_W-1:0];
    else if (p33 > hi33) d_c = dhi33[COORD_W-1:0];
    else                 d_c = '0;
    zero_c = (size33 <= 0) || (rel33 <= 0);
    full_c = rel33 >= size33;
    // rel * 255 as a shift and subtract
    num_c  = {rel33[COORD_W-1:0], {ENC_W{1'b0}}} - {{ENC_W{1'b0}}, rel33[COORD_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      in_b   <= in_c;
      inm_b  <= inm_c;
      d_b    <= d_c;
      zero_b <= zero_c;
      full_b <= full_c;
      num_b  <= num_c;
      size_b <= size33[COORD_W-1:0];
    end
  end

  // restoring divide, one quotient bit per stage, MSB first
  logic [NUM_W-1:0]   rem_q  [DIV_STEPS];
  logic [ENC_W-1:0]   qt_q   [DIV_STEPS];
  logic [COORD_W-1:0] size_q [DIV_STEPS];
  logic [SQ_W-1:0]    sq_q   [DIV_STEPS];
  logic               in_q   [DIV_STEPS];
  logic               inm_q  [DIV_STEPS];
  logic               zero_q [DIV_STEPS];
  logic               full_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [NUM_W-1:0]   rem_in, trial;
    logic [ENC_W-1:0]   q_in, q_out;
    logic [COORD_W-1:0] size_in;
    logic [SQ_W-1:0]    sq_in;
    logic               in_i, inm_i, zero_i, full_i, ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_b;
      assign q_in    = '0;
      assign size_in = size_b;
      assign sq_in   = SQ_W'(d_b) * SQ_W'(d_b);
      assign in_i    = in_b;
      assign inm_i   = inm_b;
      assign zero_i  = zero_b;
      assign full_i  = full_b;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign q_in    = qt_q[k-1];
      assign size_in = size_q[k-1];
      assign sq_in   = sq_q[k-1];
      assign in_i    = in_q[k-1];
      assign inm_i   = inm_q[k-1];
      assign zero_i  = zero_q[k-1];
      assign full_i  = full_q[k-1];
    end

    assign trial = {{ENC_W{1'b0}}, size_in} << (DIV_STEPS - 1 - k);
    assign ge    = rem_in >= trial;

    always_comb begin
      q_out = q_in;
      q_out[DIV_STEPS-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        rem_q[k]  <= ge ? rem_in - trial : rem_in;
        qt_q[k]   <= q_out;
        size_q[k] <= size_in;
        sq_q[k]   <= sq_in;
        in_q[k]   <= in_i;
        inm_q[k]  <= inm_i;
        zero_q[k] <= zero_i;
        full_q[k] <= full_i;
      end
    end
  end

  always_comb begin
    res.in_box   = in_q[DIV_STEPS-1];
    res.inside_m = inm_q[DIV_STEPS-1];
    res.sq       = sq_q[DIV_STEPS-1];
    if (zero_q[DIV_STEPS-1])      res.enc = '0;
    else if (full_q[DIV_STEPS-1]) res.enc = {ENC_W{1'b1}};
    else                          res.enc = qt_q[DIV_STEPS-1];
  end
endmodule
`default_nettype wire

// ===== hdl/bpq_merge.sv =====
// Merge of the three lanes: flag reduction and saturating distance sum.
// Depends on bpq_pkg.
`default_nettype none
module bpq_merge (
  input  wire logic                       clk,
  input  wire logic [1:0]                 en,
  input  wire bpq_pkg::lane_res_t         lx,
  input  wire bpq_pkg::lane_res_t         ly,
  input  wire bpq_pkg::lane_res_t         lz,
  output logic                            inside_res,
  output logic                            inside_margin,
  output logic [bpq_pkg::DIST_W-1:0]      dist_sq,
  output logic [bpq_pkg::ENC_W-1:0]       enc_x,
  output logic [bpq_pkg::ENC_W-1:0]       enc_y,
  output logic [bpq_pkg::ENC_W-1:0]       enc_z
);
  import bpq_pkg::*;

  logic [SQ_W:0]    sxy;
  logic [SQ_W-1:0]  sqz;
  logic             in_m, inm_m;
  logic [ENC_W-1:0] ex_m, ey_m, ez_m;
  logic [SQ_W+1:0]  total;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sxy   <= {1'b0, lx.sq} + {1'b0, ly.sq};
      sqz   <= lz.sq;
      in_m  <= lx.in_box & ly.in_box & lz.in_box;
      inm_m <= lx.inside_m & ly.inside_m & lz.inside_m;
      ex_m  <= lx.enc;
      ey_m  <= ly.enc;
      ez_m  <= lz.enc;
    end
  end

  assign total = {1'b0, sxy} + {2'b00, sqz};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      inside_res    <= in_m;
      inside_margin <= inm_m;
      if (in_m)                                    dist_sq <= '0;
      else if (total > {3'b000, DIST_MAX})         dist_sq <= DIST_MAX;
      else                                         dist_sq <= total[DIST_W-1:0];
      enc_x <= ex_m;
      enc_y <= ey_m;
      enc_z <= ez_m;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/box_point_query_core.sv =====
// Box point query: 3 axis lanes plus a merge block, 12 pipeline registers deep.
// One point per cycle is accepted while the result side does not stall.
// The depth comes from the 8 stage restoring divider of the quantizer, one bit a stage.
// Each stage moves when it is empty or its successor moves, so bubbles close up.
// Reset (rst, synchronous) clears stage valid bits and all box registers to 0.
`default_nettype none
module box_point_query_core (
  input  wire logic clk,
  input  wire logic rst,
  bpq_point_if.sink   pt,
  bpq_result_if.source res,
  bpq_cfg_if.sink     cfg
);
  import bpq_pkg::*;

  // box registers
  logic signed [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  logic [MARGIN_W-1:0]       margin;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x  <= '0;
      min_y  <= '0;
      min_z  <= '0;
      max_x  <= '0;
      max_y  <= '0;
      max_z  <= '0;
      margin <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_MIN_X:  min_x  <= cfg.data;
        REG_MIN_Y:  min_y  <= cfg.data;
        REG_MIN_Z:  min_z  <= cfg.data;
        REG_MAX_X:  max_x  <= cfg.data;
        REG_MAX_Y:  max_y  <= cfg.data;
        REG_MAX_Z:  max_z  <= cfg.data;
        REG_MARGIN: margin <= cfg.data[MARGIN_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // stage valids and per-stage advance enables
  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  assign en[STAGES] = res.ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pt.valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign pt.ready  = en[0];
  assign res.valid = vld[STAGES-1];

  // lanes
  lane_res_t lx, ly, lz;

  bpq_lane u_lane_x (
    .clk(clk), .en(en[LANE_DEPTH-1:0]), .point(pt.point_x),
    .lo(min_x), .hi(max_x), .margin(margin), .res(lx)
  );
  bpq_lane u_lane_y (
    .clk(clk), .en(en[LANE_DEPTH-1:0]), .point(pt.point_y),
    .lo(min_y), .hi(max_y), .margin(margin), .res(ly)
  );
  bpq_lane u_lane_z (
    .clk(clk), .en(en[LANE_DEPTH-1:0]), .point(pt.point_z),
    .lo(min_z), .hi(max_z), .margin(margin), .res(lz)
  );

  // merge; its last register is the output register
  bpq_merge u_merge (
    .clk(clk), .en(en[STAGES-1:LANE_DEPTH]), .lx(lx), .ly(ly), .lz(lz),
    .inside_res(res.inside_res), .inside_margin(res.inside_margin),
    .dist_sq(res.dist_sq), .enc_x(res.enc_x), .enc_y(res.enc_y), .enc_z(res.enc_z)
  );

`include "box_point_query_core_assert.svh"

  `BPQ_ASSERT_IMP(a_inside_zero_dist, res.valid && res.inside_res, res.dist_sq == '0)
  `BPQ_ASSERT_IMP(a_inside_in_margin, res.valid && res.inside_res, res.inside_margin)
  `BPQ_ASSERT_IMP(a_stall_only_full, !pt.ready, (&vld) && !res.ready)
  `BPQ_ASSERT_ALWAYS(a_cfg_always_ready, cfg.ready)
endmodule
`default_nettype wire
